>>> hw/rtl/sync_length_xor_frame_receiver_core_defines.svh
// ----------------------------------------------------------------------------
// sync length xor frame receiver: assertion macros
// shared property forms for the frame receiver checks
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLXFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SLXFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/slxfr_pkg.sv
// ----------------------------------------------------------------------------
// slxfr_pkg
// types and constants shared by the frame receiver modules
// ----------------------------------------------------------------------------
`default_nettype none

package slxfr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  localparam int CFG_INDEX_W = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_INFO_CODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_CODE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INFO_LIMIT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_LIMIT = 2'd3;

  localparam logic [7:0] INFO_CODE_RST    = 8'h01;
  localparam logic [7:0] STATUS_CODE_RST  = 8'h05;
  localparam logic [7:0] INFO_LIMIT_RST   = 8'd100;
  localparam logic [7:0] STATUS_LIMIT_RST = 8'd150;

  localparam logic [1:0] VERDICT_GOOD = 2'd0;
  localparam logic [1:0] VERDICT_BAD  = 2'd1;
  localparam logic [1:0] VERDICT_CUT  = 2'd2;

  typedef struct packed {
    logic [7:0] info_code;
    logic [7:0] status_code;
    logic [7:0] info_limit;
    logic [7:0] status_limit;
  } slxfr_cfg_t;

  typedef struct packed {
    logic       frame_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       has_byte;
    logic       frame_last;
    logic [1:0] frame_verdict;
  } slxfr_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sync_length_xor_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// sync_length_xor_frame_receiver_core
// deframer for 0x55 0xAA headed frames with length limit and xor checksum
// ----------------------------------------------------------------------------
// The receiver takes one byte per clock on the slave side and gives at most
// one result word per byte on the master side, in the cycle after the byte is
// taken. A byte is held off only while the single result register is full
// and the master side is stalled; with m_tready high the sustained rate is
// one byte every cycle. Configuration writes take effect on the next byte.
`default_nettype none

`include "sync_length_xor_frame_receiver_core_defines.svh"

module sync_length_xor_frame_receiver_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [slxfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [7:0]                           cfg_data,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,   // rx_byte
  input  wire logic                                 s_tlast,   // burst_end
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // payload_byte [7:0], payload_index [15:8], frame_verdict [17:16], zero pad
  output logic [23:0]                               m_tdata,
  output logic                                      m_tlast,   // frame_last
  output logic [1:0]                                m_tuser    // frame_kind, has_byte
);

  slxfr_pkg::slxfr_cfg_t    cfg;
  slxfr_pkg::slxfr_result_t res, out_res;
  logic                     res_valid;
  logic                     accept;

  assign accept = s_tvalid && s_tready;

  slxfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slxfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .burst_end (s_tlast),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  slxfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_valid (res_valid),
    .res       (res),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {6'd0, out_res.frame_verdict, out_res.payload_index,
                    out_res.payload_byte};
  assign m_tlast = out_res.frame_last;
  assign m_tuser = {out_res.has_byte, out_res.frame_kind};

  // a verdict-only word always closes a frame
  `SLXFR_ASSERT_NOW(a_nobyte_is_last, m_tvalid && !m_tuser[1], m_tlast,
                    "verdict-only word without last")
  // verdict is zero on words inside a frame
  `SLXFR_ASSERT_NOW(a_mid_verdict_zero, m_tvalid && !m_tlast,
                    m_tdata[17:16] == slxfr_pkg::VERDICT_GOOD,
                    "nonzero verdict before end of frame")
  // the reserved verdict code never appears
  `SLXFR_ASSERT_NOW(a_verdict_code, m_tvalid, m_tdata[17:16] != 2'd3,
                    "reserved verdict code")
  // a byte that produces a result shows it in the following cycle
  `SLXFR_ASSERT_NEXT(a_result_follows, accept && res_valid, m_tvalid,
                     "result of accepted byte not presented")

endmodule

`default_nettype wire

>>> hw/rtl/slxfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// slxfr_cfg_regs
// kind codes and length limits, written through the plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [slxfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [7:0]                           cfg_data,
  output slxfr_pkg::slxfr_cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.info_code    <= slxfr_pkg::INFO_CODE_RST;
      cfg.status_code  <= slxfr_pkg::STATUS_CODE_RST;
      cfg.info_limit   <= slxfr_pkg::INFO_LIMIT_RST;
      cfg.status_limit <= slxfr_pkg::STATUS_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slxfr_pkg::CFG_INFO_CODE:    cfg.info_code    <= cfg_data;
        slxfr_pkg::CFG_STATUS_CODE:  cfg.status_code  <= cfg_data;
        slxfr_pkg::CFG_INFO_LIMIT:   cfg.info_limit   <= cfg_data;
        slxfr_pkg::CFG_STATUS_LIMIT: cfg.status_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/slxfr_parser.sv
// ----------------------------------------------------------------------------
// slxfr_parser
// header hunt, length check and payload xor, one byte per accepted word
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_parser (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [7:0]               rx_byte,
  input  wire logic                     burst_end,
  input  wire slxfr_pkg::slxfr_cfg_t    cfg,
  output logic                          res_valid,
  output slxfr_pkg::slxfr_result_t      res
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_CHECK   = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  phase_t     phase, phase_next, next;
  logic       current_kind, current_kind_next;
  logic [7:0] length_low, length_low_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] expected_check, expected_check_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] limit;

  assign limit = current_kind ? cfg.status_limit : cfg.info_limit;

  always_comb begin
    next                = PH_HUNT;
    current_kind_next   = current_kind;
    length_low_next     = length_low;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    expected_check_next = expected_check;
    running_xor_next    = running_xor;
    res_valid           = 1'b0;
    res                 = '0;
    res.frame_kind      = current_kind;

    case (phase)
      PH_SYNC2: begin
        if (rx_byte == slxfr_pkg::SYNC_SECOND) begin
          next = PH_TYPE;
        end else if (rx_byte == slxfr_pkg::SYNC_FIRST) begin
          next = PH_SYNC2;
        end
      end
      PH_TYPE: begin
        // a byte matching both codes is the info kind
        if (rx_byte == cfg.info_code) begin
          current_kind_next = 1'b0;
          next              = PH_LEN_LO;
        end else if (rx_byte == cfg.status_code) begin
          current_kind_next = 1'b1;
          next              = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        length_low_next = rx_byte;
        next            = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (rx_byte == 8'd0 && length_low <= limit) begin
          payload_length_next = length_low;
          next                = PH_CHECK;
        end
      end
      PH_CHECK: begin
        expected_check_next = rx_byte;
        running_xor_next    = 8'd0;
        bytes_seen_next     = 8'd0;
        if (payload_length == 8'd0) begin
          res_valid         = 1'b1;
          res.frame_last    = 1'b1;
          res.frame_verdict = (rx_byte == 8'd0) ? slxfr_pkg::VERDICT_GOOD
                                                : slxfr_pkg::VERDICT_BAD;
        end else if (burst_end) begin
          res_valid         = 1'b1;
          res.frame_last    = 1'b1;
          res.frame_verdict = slxfr_pkg::VERDICT_CUT;
        end else begin
          next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_xor_next  = running_xor ^ rx_byte;
        bytes_seen_next   = bytes_seen + 8'd1;
        res_valid         = 1'b1;
        res.has_byte      = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = bytes_seen;
        if (bytes_seen_next == payload_length) begin
          res.frame_last    = 1'b1;
          res.frame_verdict = (running_xor_next == expected_check)
                              ? slxfr_pkg::VERDICT_GOOD : slxfr_pkg::VERDICT_BAD;
        end else if (burst_end) begin
          res.frame_last    = 1'b1;
          res.frame_verdict = slxfr_pkg::VERDICT_CUT;
        end else begin
          next = PH_PAYLOAD;
        end
      end
      default: begin
        // hunting, also the unused phase code
        if (rx_byte == slxfr_pkg::SYNC_FIRST) begin
          next = PH_SYNC2;
        end
      end
    endcase

    phase_next = burst_end ? PH_HUNT : next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      current_kind   <= 1'b0;
      length_low     <= 8'd0;
      payload_length <= 8'd0;
      bytes_seen     <= 8'd0;
      expected_check <= 8'd0;
      running_xor    <= 8'd0;
    end else if (accept) begin
      phase          <= phase_next;
      current_kind   <= current_kind_next;
      length_low     <= length_low_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      expected_check <= expected_check_next;
      running_xor    <= running_xor_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/slxfr_out_reg.sv
// ----------------------------------------------------------------------------
// slxfr_out_reg
// result register on the master side, refilled in the cycle it drains
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_out_reg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     load,
  input  wire logic                     res_valid,
  input  wire slxfr_pkg::slxfr_result_t res,
  output logic                          room,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output slxfr_pkg::slxfr_result_t      out_res
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire
